### rtl/sdbc_pkg.sv
// Package with shared constants, command and status types for the sample buffer cache.
package sdbc_pkg;
  localparam int NShort = 64;
  localparam int NLong = 16;
  localparam int QueueDepth = 256;
  localparam int DataW = 56;
  localparam int OutW = 72;

  localparam logic [1:0] RegShortTtl = 2'd0;
  localparam logic [1:0] RegLongTtl = 2'd1;
  localparam logic [1:0] RegShortBytes = 2'd2;
  localparam logic [1:0] RegLongBytes = 2'd3;

  localparam logic [3:0] OpNone = 4'd0;
  localparam logic [3:0] OpLoadIdx = 4'd1;
  localparam logic [3:0] OpReadEnt = 4'd2;
  localparam logic [3:0] OpTestHit = 4'd3;
  localparam logic [3:0] OpPullRd = 4'd4;
  localparam logic [3:0] OpPullWr = 4'd5;
  localparam logic [3:0] OpAllocRd = 4'd6;
  localparam logic [3:0] OpAllocWr = 4'd7;
  localparam logic [3:0] OpTickRd = 4'd8;
  localparam logic [3:0] OpTickWr = 4'd9;
  localparam logic [3:0] OpTickZero = 4'd10;
  localparam logic [3:0] OpClear = 4'd11;
  localparam logic [3:0] OpRefresh = 4'd12;

  typedef struct packed {
    logic [3:0] op;
    logic       long_q;
  } cmd_t;

  typedef struct packed {
    logic fits;
    logic ttl_zero;
    logic q_nonempty;
    logic scan_last;
    logic clear_done;
  } status_t;
endpackage

### rtl/sdbc_datapath.sv
// Datapath of the sample buffer cache: entry memories, reuse queues, fit test and result.
module sdbc_datapath #(
  parameter int NShort = sdbc_pkg::NShort,
  parameter int NLong = sdbc_pkg::NLong
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_idx,
  input  logic [12:0]              cfg_val,
  input  logic                     load,
  input  logic [sdbc_pkg::DataW-1:0] in_data,
  input  sdbc_pkg::cmd_t           cmd,
  output sdbc_pkg::status_t        status,
  output logic                     is_tick,
  output logic                     short_path,
  output logic                     pref,
  output logic [sdbc_pkg::OutW-1:0] result
);
  localparam int NTotal = NShort + NLong;
  localparam int IdxW = $clog2(NTotal);
  localparam logic [7:0] NTot8 = 8'(NTotal);
  localparam logic [7:0] NSh8 = 8'(NShort);
  localparam logic [7:0] NLo8 = 8'(NLong);

  logic [5:0] short_ttl, long_ttl;
  logic [12:0] short_bytes, long_bytes;
  logic [31:0] src_mem [NTotal];
  logic [5:0] ttl_mem [NTotal];
  logic [7:0] slot_mem [NTotal];
  logic [7:0] sq [256];
  logic [7:0] lq [256];
  logic [7:0] sq_head, sq_tail, lq_head, lq_tail;
  logic [31:0] addr;
  logic [12:0] size;
  logic [7:0] hint, idx, moved, slot_rd, q_rd;
  logic [31:0] src_rd;
  logic [5:0] ttl_rd;
  logic [7:0] clr;
  logic hit_r, fetch_r, nofree_r;
  logic [11:0] off_r;
  logic [12:0] fbytes_r;
  logic [31:0] faddr_r;
  logic [32:0] diff;
  logic [33:0] need;
  logic [12:0] bsize;
  logic idx_ok, sel_long;
  logic [7:0] tailq, headq;

  assign idx_ok = idx < NTot8;
  assign bsize = (idx < NSh8) ? short_bytes : long_bytes;
  assign diff = {1'b0, addr} - {1'b0, src_rd};
  assign need = {1'b0, diff} + {21'd0, size};
  assign sel_long = cmd.long_q;
  assign tailq = sel_long ? lq_tail : sq_tail;
  assign headq = sel_long ? lq_head : sq_head;
  assign status.fits = !diff[32] && (need <= {21'd0, bsize});
  assign status.ttl_zero = ttl_rd == 6'd0;
  assign status.q_nonempty = tailq != headq;
  assign status.scan_last = idx == NTot8 - 8'd1;
  assign status.clear_done = clr == 8'd255;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_ttl <= 6'd2; long_ttl <= 6'd60;
      short_bytes <= 13'd720; long_bytes <= 13'd1024;
      sq_head <= NSh8; sq_tail <= 8'd0; lq_head <= NLo8; lq_tail <= 8'd0;
      clr <= 8'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          sdbc_pkg::RegShortTtl: short_ttl <= cfg_val[5:0];
          sdbc_pkg::RegLongTtl: long_ttl <= cfg_val[5:0];
          sdbc_pkg::RegShortBytes: short_bytes <= cfg_val;
          sdbc_pkg::RegLongBytes: long_bytes <= cfg_val;
          default: ;
        endcase
      end
      case (cmd.op)
        sdbc_pkg::OpClear: begin
          clr <= clr + 8'd1;
          sq[clr] <= (clr < NSh8) ? clr : 8'd0;
          lq[clr] <= (clr < NLo8) ? clr + NSh8 : NSh8;
          if (clr < NTot8) begin
            src_mem[clr[IdxW-1:0]] <= 32'd0;
            ttl_mem[clr[IdxW-1:0]] <= 6'd0;
            slot_mem[clr[IdxW-1:0]] <= (clr < NSh8) ? clr : clr - NSh8;
          end
        end
        sdbc_pkg::OpPullRd: begin
          if (slot_rd != tailq) begin
            if (sel_long) lq[slot_rd] <= q_rd; else sq[slot_rd] <= q_rd;
          end
        end
        sdbc_pkg::OpPullWr: begin
          if (slot_rd != tailq && moved < NTot8) slot_mem[moved[IdxW-1:0]] <= slot_rd;
          if (sel_long) lq_tail <= lq_tail + 8'd1; else sq_tail <= sq_tail + 8'd1;
          if (idx_ok) ttl_mem[idx[IdxW-1:0]] <= sel_long ? long_ttl : short_ttl;
        end
        sdbc_pkg::OpRefresh: begin
          if (idx_ok) ttl_mem[idx[IdxW-1:0]] <= sel_long ? long_ttl : short_ttl;
        end
        sdbc_pkg::OpAllocWr: begin
          if (sel_long) lq_tail <= lq_tail + 8'd1; else sq_tail <= sq_tail + 8'd1;
          if (idx_ok) begin
            ttl_mem[idx[IdxW-1:0]] <= short_ttl;
            src_mem[idx[IdxW-1:0]] <= {addr[31:4], 4'd0};
          end
        end
        sdbc_pkg::OpTickWr: begin
          if (ttl_rd != 6'd0) begin
            ttl_mem[idx[IdxW-1:0]] <= ttl_rd - 6'd1;
            if (ttl_rd == 6'd1) begin
              if (idx < NSh8) begin
                slot_mem[idx[IdxW-1:0]] <= sq_head; sq[sq_head] <= idx;
                sq_head <= sq_head + 8'd1;
              end else begin
                slot_mem[idx[IdxW-1:0]] <= lq_head; lq[lq_head] <= idx;
                lq_head <= lq_head + 8'd1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Registered reads of entry and queue memories.
  always_ff @(posedge clk) begin
    src_rd <= idx_ok ? src_mem[idx[IdxW-1:0]] : 32'd0;
    ttl_rd <= idx_ok ? ttl_mem[idx[IdxW-1:0]] : 6'd0;
    slot_rd <= idx_ok ? slot_mem[idx[IdxW-1:0]] : 8'd0;
    q_rd <= sel_long ? lq[tailq] : sq[tailq];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      is_tick <= in_data[0];
      addr <= in_data[32:1];
      size <= in_data[45:33];
      pref <= in_data[46];
      hint <= in_data[54:47];
      short_path <= !in_data[46] && (in_data[54:47] < NSh8);
      hit_r <= 1'b0; fetch_r <= 1'b0; nofree_r <= 1'b0;
      off_r <= 12'd0; faddr_r <= 32'd0; fbytes_r <= 13'd0;
    end
    case (cmd.op)
      sdbc_pkg::OpLoadIdx: idx <= is_tick ? 8'd0 : (short_path ? hint : NSh8);
      sdbc_pkg::OpTestHit: begin
        if (status.fits) begin
          hit_r <= 1'b1; off_r <= diff[11:0];
        end else if (!short_path) begin
          idx <= idx + 8'd1;
        end
      end
      sdbc_pkg::OpPullRd: moved <= q_rd;
      sdbc_pkg::OpAllocRd: begin
        idx <= q_rd;
        nofree_r <= !sel_long && !status.q_nonempty;
      end
      sdbc_pkg::OpAllocWr: begin
        fetch_r <= 1'b1;
        faddr_r <= {addr[31:4], 4'd0};
        off_r <= {8'd0, addr[3:0]};
        fbytes_r <= bsize;
      end
      sdbc_pkg::OpTickWr: idx <= idx + 8'd1;
      sdbc_pkg::OpTickZero: idx <= 8'd0;
      default: ;
    endcase
  end

  assign result = {4'd0, nofree_r, fbytes_r, faddr_r, fetch_r, off_r,
                   (hit_r || fetch_r) ? idx : 8'd0, hit_r};
endmodule

### rtl/sdbc_ctrl.sv
// Controller state machine of the sample buffer cache.
module sdbc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              load,
  input  logic              is_tick,
  input  logic              short_path,
  input  logic              pref,
  input  sdbc_pkg::status_t status,
  output sdbc_pkg::cmd_t    cmd
);
  localparam logic [3:0] SClear = 4'd0, SIdle = 4'd1, SIdx = 4'd2, SRead = 4'd3,
    STest = 4'd4, SPullRd = 4'd5, SPullWr = 4'd6, SAllocRd = 4'd7, SAllocWr = 4'd8,
    STickRd = 4'd9, STickWr = 4'd10, SOut = 4'd11, SAllocWait = 4'd12, SPullWait = 4'd13;
  logic [3:0] state, state_next;
  logic long_q, long_q_next;

  assign in_ready = state == SIdle || (state == SOut && out_ready);
  assign out_valid = state == SOut;
  assign load = in_valid && in_ready;

  always_comb begin
    state_next = state;
    long_q_next = long_q;
    cmd.op = sdbc_pkg::OpNone;
    cmd.long_q = long_q;
    case (state)
      SClear: begin
        cmd.op = sdbc_pkg::OpClear;
        if (status.clear_done) state_next = SIdle;
      end
      SIdle: if (load) state_next = SIdx;
      SIdx: begin
        cmd.op = sdbc_pkg::OpLoadIdx;
        long_q_next = !short_path;
        state_next = is_tick ? STickRd : SRead;
      end
      SRead: state_next = STest;
      STest: begin
        cmd.op = sdbc_pkg::OpTestHit;
        if (status.fits) begin
          if (status.ttl_zero && (short_path || status.q_nonempty)) state_next = SPullRd;
          else state_next = SPullWr;
        end else if (!short_path && !status.scan_last) begin
          state_next = SRead;
        end else begin
          long_q_next = !short_path && pref && status.q_nonempty;
          state_next = SAllocWait;
        end
      end
      SPullRd: begin
        cmd.op = sdbc_pkg::OpPullRd;
        state_next = SPullWait;
      end
      SPullWait: state_next = SPullWr;
      SPullWr: begin
        cmd.op = (status.ttl_zero && (short_path || status.q_nonempty))
                 ? sdbc_pkg::OpPullWr : sdbc_pkg::OpRefresh;
        state_next = SOut;
      end
      SAllocWait: state_next = SAllocRd;
      SAllocRd: begin
        cmd.op = sdbc_pkg::OpAllocRd;
        state_next = SAllocWr;
      end
      SAllocWr: begin
        cmd.op = sdbc_pkg::OpAllocWr;
        state_next = SOut;
      end
      STickRd: state_next = STickWr;
      STickWr: begin
        cmd.op = sdbc_pkg::OpTickWr;
        if (status.scan_last) begin
          cmd.op = sdbc_pkg::OpTickWr;
          state_next = SOut;
        end else state_next = STickRd;
      end
      SOut: if (out_ready) state_next = load ? SIdx : SIdle;
      default: state_next = SIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SClear; long_q <= 1'b0;
    end else begin
      state <= state_next; long_q <= long_q_next;
    end
  end
endmodule

### rtl/sample_dma_buffer_cache_top.sv
// Top level of the sample buffer cache.
//  channel   direction  content
//  s_axis    in         func, dev_addr, request_size, prefer_long, hint_index
//  m_axis    out        hit, buffer_index, buffer_offset, fetch_*, no_free_buffer
//  cfg       in         register index and write data
// A short-path request passes through the load-index, read and test states, then a pull or an allocation.
// A long-path request repeats the read and test states for every long buffer scanned.
// A tick visits every buffer in turn, with a read state and a write state per buffer.
// After reset a clearing pass over the queues and entry memories runs before the first word is taken.
// A result waits in its register while the output is stalled.
module sample_dma_buffer_cache_top #(
  parameter int NShort = sdbc_pkg::NShort,
  parameter int NLong = sdbc_pkg::NLong
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // func, dev_addr, request_size, prefer_long, hint_index
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // hit, buffer_index, buffer_offset, fetch_start, fetch_addr, fetch_bytes, no_free_buffer
  output logic [71:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  logic load, is_tick, short_path, pref;
  sdbc_pkg::cmd_t cmd;
  sdbc_pkg::status_t status;
  logic [71:0] res;

  assign cfg_ready = 1'b1;
  assign m_axis_tdata = res;

  sdbc_ctrl u_ctrl (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .load,
    .is_tick, .short_path, .pref, .status, .cmd
  );

  sdbc_datapath #(.NShort(NShort), .NLong(NLong)) u_dp (
    .clk, .rst, .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_val(cfg_data),
    .load, .in_data(s_axis_tdata), .cmd, .status, .is_tick, .short_path, .pref,
    .result(res)
  );
endmodule
